@@ design/block_bitmap_allocator_assert.svh @@
// Assertion macros for the block bitmap allocator.
// Used by the top level; no other dependencies.
`ifndef BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH
`define BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define BBA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BBA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BBA_ASSERT(lbl, clk, rst, prop, msg)
`define BBA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ design/bba_pkg.sv @@
// Shared types and codes for the block bitmap allocator.
// No dependencies.
`default_nettype none
package bba_pkg;

  localparam int BLK_W    = 12;
  localparam int LEN_W    = 13;
  localparam int CFG_W    = 13;
  localparam int RUN_W    = 14;
  localparam int POS_W    = 14;
  localparam int SEG_BITS = 8;
  localparam int SEG_P_W  = 3;

  localparam logic [1:0] FUNC_TEST  = 2'd0;
  localparam logic [1:0] FUNC_SET   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;
  localparam logic [1:0] FUNC_FIND  = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NO_RUN = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;

  typedef struct packed {
    logic [1:0]       func;
    logic [BLK_W-1:0] block;
    logic [LEN_W-1:0] run_length;
  } bba_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             bit_value;
    logic [BLK_W-1:0] found_block;
  } bba_rsp_t;

  // result of one segment step of the run scanner
  typedef struct packed {
    logic               hit;
    logic [SEG_P_W-1:0] hit_pos;
    logic [RUN_W-1:0]   run_out;
  } bba_run_t;

endpackage
`default_nettype wire

@@ design/bba_mem.sv @@
// Bitmap word store: one write port, one registered read port.
// Uses no package.
`default_nettype none
module bba_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ design/bba_run_seg.sv @@
// Run scanner: one segment of free bits per step, carrying the run length in.
// Depends on bba_pkg.
`default_nettype none
module bba_run_seg import bba_pkg::*; (
  input  wire logic [SEG_BITS-1:0] free,
  input  wire logic [RUN_W-1:0]    run_in,
  input  wire logic [LEN_W-1:0]    len,
  input  wire logic [SEG_P_W-1:0]  last_idx,
  output bba_run_t                 res
);

  logic [RUN_W-1:0]   runlen [SEG_BITS];
  logic               has_u  [SEG_BITS];
  logic [SEG_P_W-1:0] u_idx  [SEG_BITS];
  logic [SEG_BITS-1:0] hit_vec;

  // run length ending at each position: back to the highest used bit at or
  // below it, or through the carried run when the segment is free so far
  always_comb begin
    for (int p = 0; p < SEG_BITS; p++) begin
      has_u[p] = 1'b0;
      u_idx[p] = '0;
      for (int q = 0; q <= p; q++) begin
        if (!free[q]) begin
          has_u[p] = 1'b1;
          u_idx[p] = SEG_P_W'(q);
        end
      end
      if (!free[p]) begin
        runlen[p] = '0;
      end else if (has_u[p]) begin
        runlen[p] = RUN_W'(p) - RUN_W'(u_idx[p]);
      end else begin
        runlen[p] = run_in + RUN_W'(p + 1);
      end
      hit_vec[p] = free[p] && (runlen[p] >= RUN_W'(len));
    end
  end

  always_comb begin
    res.hit     = |hit_vec;
    res.hit_pos = '0;
    for (int p = SEG_BITS - 1; p >= 0; p--) begin
      if (hit_vec[p]) begin
        res.hit_pos = SEG_P_W'(p);
      end
    end
    res.run_out = runlen[last_idx];
  end

endmodule
`default_nettype wire

@@ design/block_bitmap_allocator.sv @@
// Block bitmap allocator top level: sequencer, config register, result port.
// Depends on bba_pkg, bba_mem, bba_run_seg and the assertion macro header.
//
// Usage:
//  - Request channel: req is taken at a clock edge with start high and busy
//    low. Every request gives exactly one result beat on rsp, marked by a
//    one-cycle done strobe; the receiver cannot stall, so the beat must be
//    captured in that cycle.
//  - Config channel: cfg_data (block count) is written when cfg_valid and
//    cfg_ready are high; cfg_ready is always high. Write only while idle.
//  - Reset: synchronous rst clears the count to 4096 and starts a clearing
//    pass over the bitmap store, one word a cycle; busy stays high during
//    the pass.
//  - Test, set and clear: an out-of-range block is answered straight from
//    idle; an in-range one goes through a divide by the word width, a word
//    read and a bit update, in that order.
//  - Find walks the store word by word: a word read, then the word's 8-bit
//    segments in turn through the shared run scanner; it stops at the first
//    run, at the block limit or at the end of the store. One request is in
//    flight at a time.
`default_nettype none
`include "block_bitmap_allocator_assert.svh"
module block_bitmap_allocator import bba_pkg::*; #(
  parameter int MAX_BLOCKS = 4096,
  parameter int WORD_BITS  = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire bba_req_t         req,
  output logic                  done,
  output bba_rsp_t              rsp,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CFG_W-1:0] cfg_data
);

  localparam int NUM_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BP_W      = $clog2(WORD_BITS);
  localparam int SEGS      = (WORD_BITS + SEG_BITS - 1) / SEG_BITS;
  localparam int SEG_W     = (SEGS > 1) ? $clog2(SEGS) : 1;
  localparam int PAD_BITS  = SEGS * SEG_BITS;
  localparam int LAST_P    = (WORD_BITS - 1) % SEG_BITS;
  localparam int DIV_SH    = 24;
  localparam int DIV_RECIP = ((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int PROD_W    = DIV_SH + BLK_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ADDR  = 3'd2;
  localparam logic [2:0] S_OP    = 3'd3;
  localparam logic [2:0] S_FRD   = 3'd4;
  localparam logic [2:0] S_FSEG  = 3'd5;

  logic [2:0]          state;
  logic [AW-1:0]       clr_addr;
  logic [CFG_W-1:0]    total_blocks;
  logic [CFG_W-1:0]    lim;
  logic [CFG_W-1:0]    lim_now;
  logic [1:0]          func;
  logic [BLK_W-1:0]    blk;
  logic [LEN_W-1:0]    len;
  logic [PROD_W-1:0]   prod;
  logic [BLK_W-1:0]    quot;
  logic [AW-1:0]       word;
  logic [BP_W-1:0]     bitpos;
  logic [AW-1:0]       wcnt;
  logic [SEG_W-1:0]    seg;
  logic [POS_W-1:0]    pos;
  logic [POS_W-1:0]    pos_next;
  logic [RUN_W-1:0]    run;
  logic                last_seg;
  logic [POS_W-1:0]    found_pos;

  logic                mem_wr_en;
  logic [AW-1:0]       mem_wr_addr;
  logic [WORD_BITS-1:0] mem_wr_data;
  logic                mem_rd_en;
  logic [AW-1:0]       mem_rd_addr;
  logic [WORD_BITS-1:0] rd_data;
  logic [WORD_BITS-1:0] bit_mask;
  logic [PAD_BITS-1:0] padded;
  logic [SEG_BITS-1:0] seg_bits;
  logic [SEG_BITS-1:0] free;
  logic [SEG_P_W-1:0]  last_idx;
  bba_run_t            run_res;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    if (32'(total_blocks) > 32'(MAX_BLOCKS)) begin
      lim_now = CFG_W'(MAX_BLOCKS);
    end else begin
      lim_now = total_blocks;
    end
  end

  assign quot     = prod[DIV_SH +: BLK_W];
  assign bit_mask = WORD_BITS'(1) << bitpos;

  // store access
  always_comb begin
    mem_wr_en   = (state == S_CLEAR) || ((state == S_OP) && (func != FUNC_TEST));
    mem_wr_addr = (state == S_CLEAR) ? clr_addr : word;
    if (state == S_CLEAR) begin
      mem_wr_data = '0;
    end else if (func == FUNC_SET) begin
      mem_wr_data = rd_data | bit_mask;
    end else begin
      mem_wr_data = rd_data & ~bit_mask;
    end
    mem_rd_en   = (state == S_ADDR) || (state == S_FRD);
    mem_rd_addr = (state == S_ADDR) ? AW'(quot) : wcnt;
  end

  bba_mem #(
    .DEPTH (NUM_WORDS),
    .WIDTH (WORD_BITS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (rd_data)
  );

  // segment feed for the run scanner; blocks at or above the limit act used
  assign last_seg = (seg == SEG_W'(SEGS - 1));
  assign padded   = PAD_BITS'(rd_data);
  assign seg_bits = padded[seg * SEG_BITS +: SEG_BITS];
  assign last_idx = last_seg ? SEG_P_W'(LAST_P) : SEG_P_W'(SEG_BITS - 1);

  always_comb begin
    for (int p = 0; p < SEG_BITS; p++) begin
      free[p] = !seg_bits[p] && (!last_seg || (p <= LAST_P)) &&
                ((pos + POS_W'(p)) < POS_W'(lim));
    end
  end

  bba_run_seg u_run (
    .free     (free),
    .run_in   (run),
    .len      (len),
    .last_idx (last_idx),
    .res      (run_res)
  );

  assign pos_next  = pos + (last_seg ? POS_W'(LAST_P + 1) : POS_W'(SEG_BITS));
  assign found_pos = pos + POS_W'(run_res.hit_pos) + POS_W'(1) - POS_W'(len);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      total_blocks <= CFG_W'(4096);
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        total_blocks <= cfg_data;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(NUM_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            func <= req.func;
            blk  <= req.block;
            lim  <= lim_now;
            len  <= (req.run_length == '0) ? LEN_W'(1) : req.run_length;
            prod <= PROD_W'(req.block) * PROD_W'(DIV_RECIP);
            wcnt <= '0;
            seg  <= '0;
            pos  <= '0;
            run  <= '0;
            if (req.func == FUNC_FIND) begin
              state <= S_FRD;
            end else if (CFG_W'(req.block) >= lim_now) begin
              done <= 1'b1;
              rsp  <= '{status: ST_RANGE, bit_value: 1'b0, found_block: '0};
            end else begin
              state <= S_ADDR;
            end
          end
        end
        S_ADDR: begin
          word   <= AW'(quot);
          bitpos <= BP_W'(16'(blk) - 16'(32'(quot) * WORD_BITS));
          state  <= S_OP;
        end
        S_OP: begin
          done  <= 1'b1;
          rsp   <= '{status: ST_OK,
                     bit_value: (func == FUNC_TEST) ? rd_data[bitpos] : 1'b0,
                     found_block: '0};
          state <= S_IDLE;
        end
        S_FRD: begin
          seg   <= '0;
          state <= S_FSEG;
        end
        S_FSEG: begin
          run <= run_res.run_out;
          pos <= pos_next;
          if (run_res.hit) begin
            done  <= 1'b1;
            rsp   <= '{status: ST_OK, bit_value: 1'b0,
                       found_block: found_pos[BLK_W-1:0]};
            state <= S_IDLE;
          end else if ((pos_next >= POS_W'(lim)) ||
                       (last_seg && (wcnt == AW'(NUM_WORDS - 1)))) begin
            done  <= 1'b1;
            rsp   <= '{status: ST_NO_RUN, bit_value: 1'b0, found_block: '0};
            state <= S_IDLE;
          end else if (last_seg) begin
            wcnt  <= wcnt + AW'(1);
            state <= S_FRD;
          end else begin
            seg <= seg + SEG_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `BBA_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> busy, "reset must start the clearing pass")
  `BBA_ASSERT(a_done_idle, clk, rst, done |-> !busy, "result beat while still busy")
  `BBA_ASSERT(a_accept_progress, clk, rst, (start && !busy) |=> (busy || done), "request dropped")
  `BBA_ASSERT(a_fail_zero, clk, rst, (done && (rsp.status != ST_OK)) |-> ((rsp.bit_value == 1'b0) && (rsp.found_block == '0)), "error result carries data")
  `BBA_ASSERT(a_write_states, clk, rst, mem_wr_en |-> ((state == S_CLEAR) || (state == S_OP)), "store written outside clear or update")

endmodule
`default_nettype wire
